// ----- src/qpht_pkg.sv -----
// qpht_pkg: request and response types and status codes of the quadratic-probe hash table
// no dependencies; used by qpht_front, qpht_back, the top level and the checker

package qpht_pkg;

	localparam int KEY_W    = 31;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 3'd4;

	typedef struct packed {
		logic             command;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_index;
	} rsp_t;

endpackage

// ----- src/qpht_ram.sv -----
// qpht_ram: generic single-write, single-read memory with registered read data
// no dependencies

module qpht_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/qpht_front.sv -----
// qpht_front: accepts a request and reduces its key to the home slot, eight bits a cycle
// depends on qpht_pkg

module qpht_front #(
	parameter int TABLE_SIZE = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  qpht_pkg::req_t                req,
	output logic                          push,
	input  logic                          push_full,
	output qpht_pkg::req_t                push_req,
	output logic [$clog2(TABLE_SIZE)-1:0] push_home
);

	import qpht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);

	logic             busy_q;
	logic             done_q;
	logic [1:0]       cnt_q;
	req_t             req_q;
	logic [31:0]      sh_q;
	logic [IDX_W-1:0] rem_q;

	function automatic logic [IDX_W-1:0] rem_step8(input logic [IDX_W-1:0] r,
		input logic [7:0] byte_in);
		logic [IDX_W:0] t;
		logic [IDX_W-1:0] acc;
		acc = r;
		for (int j = 7; j >= 0; j--) begin
			t = {acc, byte_in[j]};
			if (t >= (IDX_W+1)'(TABLE_SIZE)) begin
				t = t - (IDX_W+1)'(TABLE_SIZE);
			end
			acc = t[IDX_W-1:0];
		end
		return acc;
	endfunction

	assign req_stall = busy_q;
	assign push      = busy_q && done_q && !push_full;
	assign push_req  = req_q;
	assign push_home = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (!busy_q) begin
			if (req_valid) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end
		end else if (!done_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				done_q <= 1'b1;
			end
		end else if (!push_full) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req_valid) begin
			req_q <= req;
			sh_q  <= {1'b0, req.key};
			rem_q <= '0;
		end else if (busy_q && !done_q) begin
			rem_q <= rem_step8(rem_q, sh_q[31:24]);
			sh_q  <= {sh_q[23:0], 8'd0};
		end
	end

endmodule

// ----- src/qpht_fifo.sv -----
// qpht_fifo: two-entry queue between the front and the probe sequencer
// no dependencies

module qpht_fifo #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ----- src/qpht_back.sv -----
// qpht_back: probe sequencer, walks the quadratic probe path through the slot memories
// depends on qpht_pkg and qpht_ram

module qpht_back #(
	parameter int TABLE_SIZE = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_pop,
	input  qpht_pkg::req_t                job,
	input  logic [$clog2(TABLE_SIZE)-1:0] job_home,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output qpht_pkg::rsp_t                rsp
);

	import qpht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam logic [IDX_W-1:0] TWO = IDX_W'(2 % TABLE_SIZE);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_PROBE = 2'd2;
	localparam logic [1:0] S_WB    = 2'd3;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] occ_q;
	req_t             job_q;
	logic [IDX_W-1:0] home_q;
	logic [IDX_W-1:0] off_q;
	logic [IDX_W-1:0] d_q;
	logic [CNT_W-1:0] iss_q;
	logic             rd_vld_s1;
	logic             rd_last_s1;
	logic [IDX_W-1:0] rd_addr_s1;
	rsp_t             res_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             v_rd;
	logic [KEY_W-1:0] k_rd;
	logic [IDX_W-1:0] slot_iss;
	logic             issue;
	logic             conclude;
	logic             ins_wr;
	rsp_t             res_n;
	logic             out_free;
	logic             v_we;
	logic [IDX_W-1:0] v_waddr;

	function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W+1)'(TABLE_SIZE)) begin
			s = s - (IDX_W+1)'(TABLE_SIZE);
		end
		return s[IDX_W-1:0];
	endfunction

	qpht_ram #(.W(1), .DEPTH(TABLE_SIZE)) u_valid_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (state_q != S_CLEAR),
		.raddr (slot_iss),
		.rdata (v_rd)
	);

	qpht_ram #(.W(KEY_W), .DEPTH(TABLE_SIZE)) u_key_ram (
		.clk   (clk),
		.we    (ins_wr),
		.waddr (rd_addr_s1),
		.wdata (job_q.key),
		.raddr (slot_iss),
		.rdata (k_rd)
	);

	always_comb begin
		slot_iss = mod_add(home_q, off_q);
		issue    = (state_q == S_PROBE) && (iss_q != CNT_W'(TABLE_SIZE));
		ins_wr   = (state_q == S_PROBE) && rd_vld_s1 && (job_q.command == CMD_INSERT) && !v_rd;
		v_we     = ins_wr || (state_q == S_CLEAR);
		v_waddr  = (state_q == S_CLEAR) ? clr_q : rd_addr_s1;
		out_free = !rsp_valid_q || !rsp_stall;
		job_pop  = (state_q == S_IDLE) && job_valid;
		conclude = 1'b0;
		res_n    = '{status: ST_NOT_FOUND, slot_index: '0};
		if (rd_vld_s1) begin
			if (job_q.command == CMD_INSERT) begin
				if (!v_rd) begin
					conclude = 1'b1;
					res_n    = '{status: ST_INSERTED, slot_index: SLOT_W'(rd_addr_s1)};
				end else if (rd_last_s1) begin
					conclude = 1'b1;
					res_n    = '{status: ST_NO_SLOT, slot_index: '0};
				end
			end else begin
				if (!v_rd) begin
					conclude = 1'b1;
				end else if (k_rd == job_q.key) begin
					conclude = 1'b1;
					res_n    = '{status: ST_FOUND, slot_index: SLOT_W'(rd_addr_s1)};
				end else if (rd_last_s1) begin
					conclude = 1'b1;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			occ_q       <= '0;
			iss_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue && !conclude;
			if (state_q == S_WB && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(TABLE_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (job_valid) begin
						iss_q <= '0;
						if (job.command == CMD_INSERT && occ_q == CNT_W'(TABLE_SIZE)) begin
							state_q <= S_WB;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (issue) begin
						iss_q <= iss_q + CNT_W'(1);
					end
					if (conclude) begin
						state_q <= S_WB;
						if (ins_wr) begin
							occ_q <= occ_q + CNT_W'(1);
						end
					end
				end
				S_WB: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				job_q  <= job;
				home_q <= job_home;
				off_q  <= '0;
				d_q    <= IDX_W'(1);
				res_q  <= '{status: ST_TABLE_FULL, slot_index: '0};
			end
			S_PROBE: begin
				rd_addr_s1 <= slot_iss;
				rd_last_s1 <= (iss_q == CNT_W'(TABLE_SIZE - 1));
				if (issue) begin
					off_q <= mod_add(off_q, d_q);
					d_q   <= mod_add(d_q, TWO);
				end
				if (conclude) begin
					res_q <= res_n;
				end
			end
			S_WB: begin
				if (out_free) begin
					rsp_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- src/quadratic_probe_hash_table.sv -----
// quadratic_probe_hash_table: open-addressing hash table with quadratic probing
// front reduces keys to home slots, back walks the probe path; after reset the
// valid memory is cleared slot by slot, during which no request is served
// front: accept, 4 remainder steps, queue push per request, next request taken after the push; two-entry queue after it
// back: at most TABLE_SIZE probes per request; a full-table insert is answered without probing
// async reset, active low

module quadratic_probe_hash_table #(
	parameter int TABLE_SIZE = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  qpht_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output qpht_pkg::rsp_t rsp
);

	import qpht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int JOB_W = IDX_W + $bits(req_t);

	logic             push;
	logic             push_full;
	req_t             push_req;
	logic [IDX_W-1:0] push_home;
	logic             job_valid;
	logic             job_pop;
	logic [JOB_W-1:0] job_data;
	req_t             job;
	logic [IDX_W-1:0] job_home;

	qpht_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_full (push_full),
		.push_req  (push_req),
		.push_home (push_home)
	);

	qpht_fifo #(.W(JOB_W)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_home, push_req}),
		.full      (push_full),
		.pop       (job_pop),
		.not_empty (job_valid),
		.pop_data  (job_data)
	);

	assign job      = job_data[$bits(req_t)-1:0];
	assign job_home = job_data[JOB_W-1:$bits(req_t)];

	qpht_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job),
		.job_home  (job_home),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- src/qpht_checker.sv -----
// qpht_checker: port-level checks of the hash table, bound to the top level
// depends on qpht_pkg and quadratic_probe_hash_table

module qpht_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input qpht_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input qpht_pkg::rsp_t rsp
);

	import qpht_pkg::*;

	logic [3:0] pend_q;
	logic       req_tx;
	logic       rsp_tx;

	assign req_tx = req_valid && !req_stall;
	assign rsp_tx = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_tx && !rsp_tx) begin
			pend_q <= pend_q + 4'd1;
		end else if (rsp_tx && !req_tx) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("request changed while stalled");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 4'd0)
		else $error("response without an outstanding request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == ST_INSERTED || rsp.status == ST_FOUND ||
			rsp.status == ST_NOT_FOUND || rsp.status == ST_TABLE_FULL ||
			rsp.status == ST_NO_SLOT)
		else $error("undefined status code");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_INSERTED && rsp.status != ST_FOUND |->
			rsp.slot_index == '0)
		else $error("slot index set on a miss");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (.*);

// ----- tb/probe_table_scoreboard_pkg.sv -----
// probe_table_scoreboard_pkg: scoreboard class that predicts quadratic-probe table answers
// depends on qpht_pkg for the transaction types and status codes

package probe_table_scoreboard_pkg;
	import qpht_pkg::*;

	localparam int TABLE_SIZE = 16;

	typedef struct {
		req_t request;
		rsp_t answer;
	} awaited_rsp_t;

	class probe_table_scoreboard;
		logic [KEY_W-1:0] stored_keys [TABLE_SIZE];
		bit               slot_used [TABLE_SIZE];
		int unsigned      occupied_count;
		awaited_rsp_t     awaited_rsps [$];
		int unsigned      mismatch_count;
		int unsigned      checked_count;
		int unsigned      status_tally [8];

		function new();
			foreach (slot_used[s]) slot_used[s] = 1'b0;
			foreach (status_tally[s]) status_tally[s] = 0;
			occupied_count = 0;
			mismatch_count = 0;
			checked_count  = 0;
		endfunction

		function rsp_t predict_probe(req_t r);
			rsp_t res;
			int   home;
			int   s;
			res.status     = ST_NOT_FOUND;
			res.slot_index = '0;
			home = int'(r.key % TABLE_SIZE);
			if (r.command == CMD_INSERT) begin
				if (occupied_count >= TABLE_SIZE) begin
					res.status = ST_TABLE_FULL;
				end else begin
					res.status = ST_NO_SLOT;
					for (int i = 0; i < TABLE_SIZE; i++) begin
						s = (home + (i * i) % TABLE_SIZE) % TABLE_SIZE;
						if (!slot_used[s]) begin
							stored_keys[s] = r.key;
							slot_used[s]   = 1'b1;
							occupied_count++;
							res.status     = ST_INSERTED;
							res.slot_index = SLOT_W'(s);
							break;
						end
					end
				end
			end else begin
				for (int i = 0; i < TABLE_SIZE; i++) begin
					s = (home + (i * i) % TABLE_SIZE) % TABLE_SIZE;
					if (!slot_used[s]) break;
					if (stored_keys[s] == r.key) begin
						res.status     = ST_FOUND;
						res.slot_index = SLOT_W'(s);
						break;
					end
				end
			end
			return res;
		endfunction

		function void note_request(req_t r);
			awaited_rsp_t p;
			p.request = r;
			p.answer  = predict_probe(r);
			status_tally[p.answer.status]++;
			awaited_rsps.push_back(p);
		endfunction

		function void check_response(rsp_t got);
			awaited_rsp_t p;
			if (awaited_rsps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected response: status %0d slot %0d",
						got.status, got.slot_index);
				return;
			end
			p = awaited_rsps.pop_front();
			checked_count++;
			if (got.status !== p.answer.status || got.slot_index !== p.answer.slot_index) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("mismatch: command %0d key 0x%08h expected status %0d slot %0d, got status %0d slot %0d",
						p.request.command, p.request.key, p.answer.status,
						p.answer.slot_index, got.status, got.slot_index);
			end
		endfunction

		function int outstanding();
			return awaited_rsps.size();
		endfunction
	endclass

endpackage

// ----- tb/tb_top.sv -----
// tb_top: testbench top for quadratic_probe_hash_table, directed then random transactions
// depends on qpht_pkg, probe_table_scoreboard_pkg and the block's RTL

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import qpht_pkg::*;
	import probe_table_scoreboard_pkg::*;

	localparam int RANDOM_ITEMS = 1750;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	bit                    steady = 1'b0;
	int unsigned           cycle_count = 0;
	logic [KEY_W-1:0]      key_pool [$];
	int                    fill_homes [10] = '{3, 5, 6, 7, 8, 10, 11, 12, 13, 14};
	probe_table_scoreboard sb;

	quadratic_probe_hash_table #(.TABLE_SIZE(TABLE_SIZE)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= arst_n && !steady && ($urandom_range(99) < 21);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) sb.note_request(req);
			if (rsp_valid && !rsp_stall) sb.check_response(rsp);
		end
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_request(input logic command, input logic [KEY_W-1:0] key);
		req_t r;
		r.command = command;
		r.key     = key;
		while (!steady && $urandom_range(99) < 21) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (command == CMD_INSERT && key_pool.size() < 64) key_pool.push_back(key);
	endtask

	task automatic wait_for_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	initial begin
		logic             command;
		logic [KEY_W-1:0] key;
		int unsigned      pick;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, chain on home 0, full probe path, then fill to capacity
		send_request(CMD_SEARCH, 31'd5);
		send_request(CMD_INSERT, 31'd0);
		send_request(CMD_INSERT, 31'h7FFF_FFFF);
		send_request(CMD_INSERT, 31'd16);
		send_request(CMD_INSERT, 31'd0);
		send_request(CMD_INSERT, 31'd32);
		send_request(CMD_INSERT, 31'd48);
		send_request(CMD_SEARCH, 31'd0);
		send_request(CMD_SEARCH, 31'd48);
		send_request(CMD_SEARCH, 31'd32);
		send_request(CMD_SEARCH, 31'h7FFF_FFFF);
		send_request(CMD_SEARCH, 31'h7FFF_FFEF);
		send_request(CMD_INSERT, 31'h4000_0002);
		foreach (fill_homes[j]) begin
			key = KEY_W'($urandom);
			key[SLOT_W-1:0] = SLOT_W'(fill_homes[j]);
			send_request(CMD_INSERT, key);
		end
		send_request(CMD_INSERT, 31'd0);
		send_request(CMD_INSERT, 31'h7FFF_FFFF);
		wait_for_responses();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady <= (n >= 500 && n < 800);
			if (n == 1000) wait_for_responses();
			pick    = $urandom_range(99);
			command = ($urandom_range(99) < 40) ? CMD_INSERT : CMD_SEARCH;
			if (pick < 45)
				key = key_pool[$urandom_range(key_pool.size() - 1)];
			else if (pick < 75)
				key = KEY_W'($urandom);
			else
				key = KEY_W'($urandom_range(63));
			send_request(command, key);
		end

		wait_for_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d responses checked: %0d inserted, %0d found, %0d not found",
			sb.checked_count, sb.status_tally[ST_INSERTED], sb.status_tally[ST_FOUND],
			sb.status_tally[ST_NOT_FOUND]);
		$display("table full %0d, no slot %0d, mismatches %0d",
			sb.status_tally[ST_TABLE_FULL], sb.status_tally[ST_NO_SLOT], sb.mismatch_count);
		if (sb.mismatch_count == 0 && sb.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- quadratic_probe_hash_table.f -----
src/qpht_pkg.sv
src/qpht_ram.sv
src/qpht_front.sv
src/qpht_fifo.sv
src/qpht_back.sv
src/quadratic_probe_hash_table.sv
src/qpht_checker.sv
tb/probe_table_scoreboard_pkg.sv
tb/tb_top.sv
